// ----- rtl/core/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and digit decoding for the time telegram parser.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int STORE_DEPTH    = 23;
	localparam int MESSAGE_LIMIT  = 32;
	localparam int HUNT_LIMIT     = 200;
	localparam int QUEUE_DEPTH    = 2;
	localparam int OFFSET_W       = 10;
	localparam int OFFSET_RESET   = 22;

	localparam logic [7:0] HEAD_CHAR  = 8'h3C;
	localparam logic [7:0] END_CHAR   = 8'h0D;
	localparam logic [7:0] SYNC_CHAR  = 8'h46;
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;

	localparam int POS_HOURS   = 1;
	localparam int POS_MINUTES = 3;
	localparam int POS_SECONDS = 21;
	localparam int POS_DAY     = 5;
	localparam int POS_MONTH   = 7;
	localparam int POS_YEAR    = 9;
	localparam int POS_WEEKDAY = 11;
	localparam int POS_SYNC    = 12;

	localparam int YEAR_BASE   = 2000;
	localparam int DAYS_YEAR   = 365;
	localparam int MONTH_MUL   = 367;
	localparam int DAY_BIAS    = 719499;
	localparam int RECIP12     = 43691;
	localparam int RECIP12_SH  = 19;
	localparam int CENT_LO     = 19;
	localparam int CENT_HI     = 20;
	localparam int QUAD_LO     = 4;
	localparam int QUAD_HI     = 5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TIMEOUT   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_BAD_FIELD = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [6:0]  day_of_month;
		logic [6:0]  month_number;
		logic [6:0]  year_in_century;
		logic [3:0]  weekday;
		logic        remote_synced;
		logic [31:0] recording_time;
	} tte_entry_t;

	typedef struct packed {
		tte_entry_t  fields;
		logic [32:0] epoch_seconds;
	} tte_result_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] val;
	} tte_field_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PROD,
		BK_DAYS,
		BK_SUM,
		BK_HOUR,
		BK_MIN,
		BK_SEC,
		BK_OUT
	} bk_state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= DIGIT_LO) && (c <= DIGIT_HI);
	endfunction

	function automatic tte_field_t decode_pair(input logic [7:0] c0, input logic [7:0] c1);
		tte_field_t r;
		logic [6:0] d0;
		logic [6:0] d1;
		r.ok  = 1'b1;
		r.val = '0;
		d0    = {3'b000, c0[3:0]};
		d1    = {3'b000, c1[3:0]};
		if (c0 == NUL_CHAR) begin
			r.val = '0;
		end else if (!is_digit(c0)) begin
			r.ok = 1'b0;
		end else if (c1 == NUL_CHAR) begin
			r.val = d0;
		end else if (!is_digit(c1)) begin
			r.ok = 1'b0;
		end else begin
			r.val = 7'(d0 * 7'd10 + d1);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/time_telegram_parser_epoch.sv -----
// ----------------------------------------------------------------------------
// time_telegram_parser_epoch
// Serial time telegram parser that yields decoded fields and Unix seconds.
// ----------------------------------------------------------------------------
// Input side is a queue: drive rx_byte and rx_time with push; a transaction
// completes at a clock edge where push is high and full is low. Each
// character is classified in the cycle it is taken, so one character per
// cycle is accepted while the entry queue has room.
// Result side is a queue too: while empty is low the oldest result stands on
// the result ports; a transaction completes where pop is high and empty is low.
// The edge that takes the character causing a result (head timeout, overflow
// or end of telegram) writes its entry into the queue; the seven-step
// conversion sequencer then takes it through PROD, DAYS, SUM, HOUR, MIN, SEC
// and OUT to the result ports. It handles one entry at a time and takes no
// new one until its result is popped; the entry queue absorbs bursts.
// A stalled receiver holds its result; the queue then fills, and full stays
// high until pop frees the result register and the sequencer takes an entry.
// timestamp_offset is written over cfg_valid/cfg_ready/cfg_data; the user must
// write it only while idle, which the block does not enforce; cfg_ready is always high.
// Reset clears hunting state, the stored telegram, the queue and the result
// valid flag, and loads the offset with 22.
// ----------------------------------------------------------------------------
module time_telegram_parser_epoch #(
	parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   rx_byte,
	input  logic [31:0]                  rx_time,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tte_pkg::OFFSET_W-1:0] cfg_data,
	input  logic                         pop,
	output logic                         empty,
	output logic [1:0]                   status,
	output logic [6:0]                   hours,
	output logic [6:0]                   minutes,
	output logic [6:0]                   seconds,
	output logic [6:0]                   day_of_month,
	output logic [6:0]                   month_number,
	output logic [6:0]                   year_in_century,
	output logic [3:0]                   weekday,
	output logic [32:0]                  epoch_seconds,
	output logic                         remote_synced,
	output logic [31:0]                  recording_time
);
	import tte_pkg::*;

	logic [OFFSET_W-1:0] offset_q;
	logic                accept;
	logic                ent_valid;
	tte_entry_t          ent;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	tte_entry_t          q_data;
	tte_result_t         res;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_q <= OFFSET_W'(OFFSET_RESET);
		else if (cfg_valid)
			offset_q <= cfg_data;
	end

	tte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.rx_byte   (rx_byte),
		.rx_time   (rx_time),
		.offset    (offset_q),
		.ent_valid (ent_valid),
		.ent       (ent)
	);

	tte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ent_valid),
		.wr_data (ent),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_empty (q_empty)
	);

	tte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign status          = res.fields.status;
	assign hours           = res.fields.hours;
	assign minutes         = res.fields.minutes;
	assign seconds         = res.fields.seconds;
	assign day_of_month    = res.fields.day_of_month;
	assign month_number    = res.fields.month_number;
	assign year_in_century = res.fields.year_in_century;
	assign weekday         = res.fields.weekday;
	assign epoch_seconds   = res.epoch_seconds;
	assign remote_synced   = res.fields.remote_synced;
	assign recording_time  = res.fields.recording_time;

endmodule

// ----- rtl/core/tte_front.sv -----
// ----------------------------------------------------------------------------
// tte_front
// Hunts for the head character, stores the telegram and classifies each
// character; at the end character it decodes the fields into a queue entry,
// and a hunt timeout or an overflow also yields an entry.
module tte_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [7:0]                  rx_byte,
	input  logic [31:0]                 rx_time,
	input  logic [tte_pkg::OFFSET_W-1:0] offset,
	output logic                        ent_valid,
	output tte_pkg::tte_entry_t         ent
);
	import tte_pkg::*;

	localparam int IDX_W = $clog2(STORE_DEPTH);

	logic       collecting_q;
	logic [7:0] hunt_cnt_q;
	logic [7:0] wr_idx_q;
	logic [7:0] msg_q [STORE_DEPTH];
	logic [7:0] msg_nxt [STORE_DEPTH];

	logic       collecting_d;
	logic [7:0] hunt_cnt_d;
	logic [7:0] wr_idx_d;
	logic [7:0] hunt_inc;
	logic [7:0] wr_inc;

	tte_field_t f_hours, f_minutes, f_seconds, f_day, f_month, f_year, f_weekday;
	logic       fields_ok;

	assign hunt_inc = hunt_cnt_q + 8'd1;
	assign wr_inc   = wr_idx_q + 8'd1;

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			msg_nxt[i] = msg_q[i];
			if (!collecting_q) begin
				if (i == 0 && hunt_inc < 8'(HUNT_LIMIT) && rx_byte == HEAD_CHAR)
					msg_nxt[i] = rx_byte;
			end else if (wr_idx_q < 8'(STORE_DEPTH) && wr_idx_q[IDX_W-1:0] == IDX_W'(i)) begin
				msg_nxt[i] = rx_byte;
			end
		end
	end

	assign f_hours   = decode_pair(msg_nxt[POS_HOURS],   msg_nxt[POS_HOURS+1]);
	assign f_minutes = decode_pair(msg_nxt[POS_MINUTES], msg_nxt[POS_MINUTES+1]);
	assign f_seconds = decode_pair(msg_nxt[POS_SECONDS], msg_nxt[POS_SECONDS+1]);
	assign f_day     = decode_pair(msg_nxt[POS_DAY],     msg_nxt[POS_DAY+1]);
	assign f_month   = decode_pair(msg_nxt[POS_MONTH],   msg_nxt[POS_MONTH+1]);
	assign f_year    = decode_pair(msg_nxt[POS_YEAR],    msg_nxt[POS_YEAR+1]);
	assign f_weekday = decode_pair(msg_nxt[POS_WEEKDAY], NUL_CHAR);

	assign fields_ok = f_hours.ok & f_minutes.ok & f_seconds.ok & f_day.ok &
		f_month.ok & f_year.ok & f_weekday.ok;

	always_comb begin
		collecting_d = collecting_q;
		hunt_cnt_d   = hunt_cnt_q;
		wr_idx_d     = wr_idx_q;
		ent_valid    = 1'b0;
		ent          = '0;
		if (!collecting_q) begin
			if (hunt_inc >= 8'(HUNT_LIMIT)) begin
				hunt_cnt_d = '0;
				wr_idx_d   = '0;
				ent_valid  = 1'b1;
				ent.status = ST_TIMEOUT;
			end else if (rx_byte == HEAD_CHAR) begin
				collecting_d = 1'b1;
				hunt_cnt_d   = '0;
				wr_idx_d     = 8'd1;
			end else begin
				hunt_cnt_d = hunt_inc;
			end
		end else if (rx_byte != END_CHAR) begin
			if (wr_inc >= 8'(MESSAGE_LIMIT)) begin
				collecting_d = 1'b0;
				hunt_cnt_d   = '0;
				wr_idx_d     = '0;
				ent_valid    = 1'b1;
				ent.status   = ST_OVERFLOW;
			end else begin
				wr_idx_d = wr_inc;
			end
		end else begin
			collecting_d       = 1'b0;
			hunt_cnt_d         = '0;
			wr_idx_d           = '0;
			ent_valid          = 1'b1;
			ent.recording_time = rx_time - {{(32-OFFSET_W){1'b0}}, offset};
			if (!fields_ok) begin
				ent.status = ST_BAD_FIELD;
			end else begin
				ent.status          = ST_OK;
				ent.hours           = f_hours.val;
				ent.minutes         = f_minutes.val;
				ent.seconds         = f_seconds.val;
				ent.day_of_month    = f_day.val;
				ent.month_number    = f_month.val;
				ent.year_in_century = f_year.val;
				ent.weekday         = f_weekday.val[3:0];
				ent.remote_synced   = (msg_nxt[POS_SYNC] == SYNC_CHAR);
			end
		end
		if (!in_valid)
			ent_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			hunt_cnt_q   <= '0;
			wr_idx_q     <= '0;
			for (int i = 0; i < STORE_DEPTH; i++)
				msg_q[i] <= '0;
		end else if (in_valid) begin
			collecting_q <= collecting_d;
			hunt_cnt_q   <= hunt_cnt_d;
			wr_idx_q     <= wr_idx_d;
			for (int i = 0; i < STORE_DEPTH; i++)
				msg_q[i] <= msg_nxt[i];
		end
	end

endmodule

// ----- rtl/core/tte_queue.sv -----
// ----------------------------------------------------------------------------
// tte_queue
// Short first-in first-out buffer of decoded entries between front and back.
// ----------------------------------------------------------------------------
module tte_queue #(
	parameter int DEPTH = tte_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  tte_pkg::tte_entry_t wr_data,
	output logic                q_full,
	input  logic                rd_en,
	output tte_pkg::tte_entry_t rd_data,
	output logic                q_empty
);
	import tte_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tte_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en & ~q_full;
	assign do_rd   = rd_en & ~q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/tte_back.sv -----
// ----------------------------------------------------------------------------
// tte_back
// Sequencer that turns one decoded entry into seconds since 1970 and holds
// the finished result until it is taken.
// ----------------------------------------------------------------------------
module tte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  tte_pkg::tte_entry_t  q_data,
	output logic                 q_pop,
	input  logic                 res_pop,
	output logic                 res_empty,
	output tte_pkg::tte_result_t res
);
	import tte_pkg::*;

	bk_state_t   state_q;
	bk_state_t   state_d;
	logic        load_out;

	tte_entry_t  ent_q;
	logic [11:0] year_q;
	logic [19:0] prod_a_q;
	logic [15:0] prod_b_q;
	logic [11:0] q12_q;
	logic [19:0] base_q;
	logic [32:0] acc_q;
	tte_result_t out_q;
	logic        out_valid_q;

	logic [11:0] year_adj;
	logic [6:0]  month_adj;
	logic [31:0] recip;
	logic [20:0] base;
	logic        late_cent;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!q_empty && !out_valid_q) state_d = BK_PROD;
			BK_PROD: state_d = BK_DAYS;
			BK_DAYS: state_d = BK_SUM;
			BK_SUM:  state_d = BK_HOUR;
			BK_HOUR: state_d = BK_MIN;
			BK_MIN:  state_d = BK_SEC;
			BK_SEC:  state_d = BK_OUT;
			BK_OUT:  state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == BK_IDLE) && !q_empty && !out_valid_q;
		load_out = (state_q == BK_OUT);
	end

	always_comb begin
		if (ent_q.month_number <= 7'd2) begin
			month_adj = ent_q.month_number + 7'd10;
			year_adj  = 12'(YEAR_BASE - 1) + {5'b0, ent_q.year_in_century};
		end else begin
			month_adj = ent_q.month_number - 7'd2;
			year_adj  = 12'(YEAR_BASE) + {5'b0, ent_q.year_in_century};
		end
	end

	assign recip     = 32'(prod_b_q) * 32'(RECIP12);
	assign late_cent = (year_q >= 12'(YEAR_BASE));
	assign base = 21'(prod_a_q) + 21'(year_q[11:2])
		- (late_cent ? 21'(CENT_HI) : 21'(CENT_LO))
		+ (late_cent ? 21'(QUAD_HI) : 21'(QUAD_LO))
		+ 21'(ent_q.day_of_month) - 21'(DAY_BIAS);

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: if (q_pop) ent_q <= q_data;
			BK_PROD: begin
				year_q   <= year_adj;
				prod_a_q <= 20'(year_adj) * 20'(DAYS_YEAR);
				prod_b_q <= 16'(month_adj * 16'(MONTH_MUL));
			end
			BK_DAYS: begin
				q12_q  <= recip[RECIP12_SH +: 12];
				base_q <= base[19:0];
			end
			BK_SUM:  acc_q <= 33'(base_q) + 33'(q12_q);
			BK_HOUR: acc_q <= 33'(acc_q * 33'd24) + 33'(ent_q.hours);
			BK_MIN:  acc_q <= 33'(acc_q * 33'd60) + 33'(ent_q.minutes);
			BK_SEC:  acc_q <= 33'(acc_q * 33'd60) + 33'(ent_q.seconds);
			BK_OUT: begin
				out_q.fields        <= ent_q;
				out_q.epoch_seconds <= (ent_q.status == ST_OK) ? acc_q : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (res_pop)
				out_valid_q <= 1'b0;
		end
	end

	assign res_empty = ~out_valid_q;
	assign res       = out_q;

endmodule
